// File: rtl/halton_radical_inverse_assert.svh
// Assertion macros shared by the radical inverse RTL.
// Needs nothing else; included by the modules that check their own logic.
`ifndef HALTON_RADICAL_INVERSE_ASSERT_SVH
`define HALTON_RADICAL_INVERSE_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define HRI_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
// Check a property on every rising edge, reset included.
`define HRI_ASSERT_ALW(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");
`else
`define HRI_ASSERT_RST(label, clk, rst_n, prop)
`define HRI_ASSERT_ALW(label, clk, prop)
`endif

`endif

// File: rtl/hri_pkg.sv
// Package for the radical inverse block: field widths, defaults, register
// map and the command type of the shared divider. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hri_pkg;

  // Fixed field widths
  localparam int IndexW = 32;
  localparam int ValueW = 32;
  localparam int BaseW  = 8;

  // Parameter defaults
  localparam int IndexBitsDef = 32;
  localparam int FracBitsDef  = 32;

  // Configuration register
  localparam logic [BaseW-1:0] BaseReset = 8'd2;
  localparam logic [BaseW-1:0] BaseMin   = 8'd2;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam logic [CfgAddrW-3:0] RegBase = 1'b0;

  // Divider operating mode
  typedef enum logic {
    DivDigit = 1'b0,  // split index by base: quotient and digit
    DivFrac  = 1'b1   // fraction bits of num / den
  } div_mode_e;

  typedef struct packed {
    logic      start;
    div_mode_e mode;
  } div_cmd_t;

endpackage

`default_nettype wire

// File: rtl/hri_if.sv
// Valid/ready channel interfaces for index and value beats.
// Depends on hri_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hri_in_if;
  import hri_pkg::*;
  logic              valid;
  logic              ready;
  logic [IndexW-1:0] index;
  modport source (output valid, output index, input ready);
  modport sink   (input valid, input index, output ready);
endinterface

interface hri_out_if;
  import hri_pkg::*;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// File: rtl/hri_cfg.sv
// APB-style register file holding the base register.
// Depends on hri_pkg for the register map and reset value.
`timescale 1ns / 1ps
`default_nettype none

module hri_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel_i,
  input  wire logic                           penable_i,
  input  wire logic                           pwrite_i,
  input  wire logic [hri_pkg::CfgAddrW-1:0]   paddr_i,
  input  wire logic [hri_pkg::CfgDataW-1:0]   pwdata_i,
  output logic      [hri_pkg::CfgDataW-1:0]   prdata_o,
  output logic                                pready_o,
  output logic      [hri_pkg::BaseW-1:0]      base_eff_o
);
  import hri_pkg::*;

  logic [BaseW-1:0]      base_q;
  logic [CfgAddrW-3:0]   reg_idx;
  logic                  wr_en;

  assign reg_idx  = paddr_i[CfgAddrW-1:2];
  assign wr_en    = psel_i & penable_i & pwrite_i & (reg_idx == RegBase);
  assign pready_o = 1'b1;

  // Store the base on a write beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseReset;
    end else if (wr_en) begin
      base_q <= pwdata_i[BaseW-1:0];
    end
  end

  // Read back the raw register
  assign prdata_o = (reg_idx == RegBase) ? CfgDataW'(base_q) : '0;

  // Bases zero and one act as two
  assign base_eff_o = (base_q < BaseMin) ? BaseMin : base_q;

endmodule

`default_nettype wire

// File: rtl/hri_divider.sv
// Shared restoring divider, one quotient bit per cycle. Splits an index by
// the base, or forms the fraction bits of num / den. Depends on hri_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "halton_radical_inverse_assert.svh"

module hri_divider #(
  parameter int IndexBits = hri_pkg::IndexBitsDef,
  parameter int FracBits  = hri_pkg::FracBitsDef,
  localparam int DenW     = IndexBits + hri_pkg::BaseW,
  localparam int QuoWMax  = (IndexBits > FracBits) ? IndexBits : FracBits,
  localparam int QuoW     = (QuoWMax > hri_pkg::ValueW) ? QuoWMax : hri_pkg::ValueW
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire hri_pkg::div_cmd_t           cmd_i,
  input  wire logic [IndexBits-1:0]        n_i,
  input  wire logic [hri_pkg::BaseW-1:0]   b_i,
  input  wire logic [DenW-1:0]             num_i,
  input  wire logic [DenW-1:0]             den_i,
  output logic                             done_o,
  output logic      [QuoW-1:0]             quo_o,
  output logic      [DenW-1:0]             rem_o
);
  import hri_pkg::*;

  localparam int StepMax = QuoWMax;
  localparam int CntW    = $clog2(StepMax + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DenW-1:0]      rem_q, rem_d;
  logic [DenW-1:0]      div_q, div_d;
  logic [QuoW-1:0]      quo_q, quo_d;
  logic [IndexBits-1:0] shin_q, shin_d;
  logic [DenW:0]        trial;
  logic [DenW:0]        diff;
  logic                 ge;

  // One restoring step: bring down a bit, subtract if it fits
  assign trial = {rem_q, shin_q[IndexBits-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    shin_d = shin_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      quo_d  = '0;
      if (cmd_i.mode == DivDigit) begin
        cnt_d  = CntW'(IndexBits);
        rem_d  = '0;
        div_d  = DenW'(b_i);
        shin_d = n_i;
      end else begin
        cnt_d  = CntW'(FracBits);
        rem_d  = num_i;
        div_d  = den_i;
        shin_d = '0;
      end
    end else if (busy_q) begin
      rem_d  = ge ? diff[DenW-1:0] : trial[DenW-1:0];
      quo_d  = {quo_q[QuoW-2:0], ge};
      shin_d = {shin_q[IndexBits-2:0], 1'b0};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers hold their last result while idle
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    quo_q  <= quo_d;
    shin_q <= shin_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  `HRI_ASSERT_RST(a_no_restart, clk_i, rst_ni, busy_q |-> !cmd_i.start)
  `HRI_ASSERT_RST(a_rem_below_div, clk_i, rst_ni, busy_q |-> (rem_q < div_q))
  `HRI_ASSERT_RST(a_done_after_busy, clk_i, rst_ni, done_q |-> ($past(busy_q) && !busy_q))
  `HRI_ASSERT_ALW(a_reset_idle, clk_i, !rst_ni |=> (!busy_q && !done_q))

endmodule

`default_nettype wire

// File: rtl/halton_radical_inverse.sv
// Radical inverse unit, top level: sequencer, digit accumulator, output
// register. Depends on hri_pkg, hri_if, hri_cfg and hri_divider.
//
//   channel   dir   handshake            payload
//   in_i      in    valid/ready          index  [31:0]
//   out_o     out   valid/ready          value  [31:0]
//   apb       in    psel/penable/pready  base   [7:0] at byte address 0
//
// An index with k base digits runs k digit steps and then one fraction step
// on the shared bit-serial divider, one quotient bit a cycle. Index zero
// goes straight to the fraction step. in_i.ready is high only while no
// item is in flight; a finished value waits in the output register while
// the next index is already accepted. Reset leaves base at two.
`timescale 1ns / 1ps
`default_nettype none
`include "halton_radical_inverse_assert.svh"

module halton_radical_inverse #(
  parameter int IndexBits = hri_pkg::IndexBitsDef,
  parameter int FracBits  = hri_pkg::FracBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hri_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [hri_pkg::CfgDataW-1:0]  pwdata,
  output logic      [hri_pkg::CfgDataW-1:0]  prdata,
  output logic                               pready,
  hri_in_if.sink                             in_i,
  hri_out_if.source                          out_o
);
  import hri_pkg::*;

  localparam int DenW    = IndexBits + BaseW;
  localparam int QuoWMax = (IndexBits > FracBits) ? IndexBits : FracBits;
  localparam int QuoW    = (QuoWMax > ValueW) ? QuoWMax : ValueW;
  localparam int ProdW   = DenW + BaseW;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StDigit = 3'd2;
  localparam logic [2:0] StAccum = 3'd3;
  localparam logic [2:0] StFrac  = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [IndexBits-1:0] n_q, n_d, n_in;
  logic [DenW-1:0]      rev_q, rev_d;
  logic [DenW-1:0]      den_q, den_d;
  logic                 out_valid_q, out_valid_d;
  logic [ValueW-1:0]    out_value_q, out_value_d;
  logic [BaseW-1:0]     base_eff;
  div_cmd_t             div_cmd;
  logic                 div_done;
  logic [QuoW-1:0]      div_quo;
  logic [DenW-1:0]      div_rem;
  logic [ProdW-1:0]     rev_prod;
  logic [ProdW-1:0]     den_prod;
  logic                 in_fire;

  hri_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .prdata_o   (prdata),
    .pready_o   (pready),
    .base_eff_o (base_eff)
  );

  hri_divider #(
    .IndexBits (IndexBits),
    .FracBits  (FracBits)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .n_i    (n_q),
    .b_i    (base_eff),
    .num_i  (rev_q),
    .den_i  (den_q),
    .done_o (div_done),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  // Fit the index beat to the working width
  if (IndexBits <= IndexW) begin : g_idx_trunc
    assign n_in = in_i.index[IndexBits-1:0];
  end else begin : g_idx_ext
    assign n_in = {{(IndexBits - IndexW){1'b0}}, in_i.index};
  end

  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid & in_i.ready;

  // Append one mirrored digit and scale the denominator
  assign rev_prod = ProdW'(rev_q) * ProdW'(base_eff);
  assign den_prod = ProdW'(den_q) * ProdW'(base_eff);

  always_comb begin
    state_d       = state_q;
    n_d           = n_q;
    rev_d         = rev_q;
    den_d         = den_q;
    out_valid_d   = out_valid_q;
    out_value_d   = out_value_q;
    div_cmd.start = 1'b0;
    div_cmd.mode  = DivDigit;

    // Drop the value once taken
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          n_d     = n_in;
          rev_d   = '0;
          den_d   = DenW'(1);
          state_d = StCheck;
        end
      end
      StCheck: begin
        div_cmd.start = 1'b1;
        if (n_q == '0) begin
          div_cmd.mode = DivFrac;
          state_d      = StFrac;
        end else begin
          div_cmd.mode = DivDigit;
          state_d      = StDigit;
        end
      end
      StDigit: begin
        if (div_done) begin
          state_d = StAccum;
        end
      end
      StAccum: begin
        rev_d   = rev_prod[DenW-1:0] + DenW'(div_rem[BaseW-1:0]);
        den_d   = den_prod[DenW-1:0];
        n_d     = div_quo[IndexBits-1:0];
        state_d = StCheck;
      end
      StFrac: begin
        if (div_done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_value_d = div_quo[ValueW-1:0];
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    rev_q       <= rev_d;
    den_q       <= den_d;
    out_value_q <= out_value_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.value = out_value_q;

  `HRI_ASSERT_RST(a_accept_to_check, clk_i, rst_ni, in_fire |=> (state_q == StCheck))
  `HRI_ASSERT_RST(a_frac_proper, clk_i, rst_ni, (div_cmd.start && div_cmd.mode == DivFrac) |-> (rev_q < den_q))
  `HRI_ASSERT_RST(a_done_expected, clk_i, rst_ni, div_done |-> (state_q == StDigit || state_q == StFrac))

endmodule

`default_nettype wire

// File: tb/tb_halton_radical_inverse.sv
// Testbench for halton_radical_inverse: sends sample indices under several radix settings,
// predicts each radical inverse exactly, and checks the output beats in order.
// Depends on hri_pkg, hri_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_halton_radical_inverse;
  import hri_pkg::*;

  localparam int IndexBits  = IndexBitsDef;
  localparam int FracBits   = FracBitsDef;
  localparam int StallLimit = 20000;
  localparam int PhaseItems = 90;
  localparam int HoldCycles = 1500;

  localparam logic [CfgAddrW-1:0] BaseAddr   = {RegBase, 2'b00};
  localparam logic [CfgAddrW-1:0] UnusedAddr = {~RegBase, 2'b00};

  typedef struct packed {
    logic [IndexW-1:0] index;
    logic [ValueW-1:0] value;
  } inverse_exp_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  hri_in_if  in_if ();
  hri_out_if out_if ();

  inverse_exp_t     expected_inverses[$];
  logic [BaseW-1:0] cfg_base;
  int               error_count;
  int               idle_cycles;
  bit               sender_idle;
  bit               sink_idle;
  int               sink_hold_cycles;

  halton_radical_inverse #(
    .IndexBits(IndexBits),
    .FracBits (FracBits)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Mirror the base-b digits of idx and divide out the fraction exactly
  function automatic logic [ValueW-1:0] radical_inverse(input logic [IndexW-1:0] idx,
                                                         input logic [BaseW-1:0] radix);
    logic [63:0] b;
    logic [63:0] n;
    logic [63:0] mirrored;
    logic [63:0] scale;
    logic [63:0] rem;
    logic [63:0] quo;
    b = (radix < BaseMin) ? 64'(BaseMin) : 64'(radix);
    n = 64'(idx) & ((64'd1 << IndexBits) - 64'd1);
    mirrored = 64'd0;
    scale = 64'd1;
    while (n != 64'd0) begin
      mirrored = mirrored * b + (n % b);
      scale = scale * b;
      n = n / b;
    end
    rem = mirrored;
    quo = 64'd0;
    for (int i = 0; i < FracBits; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= scale) begin
        rem = rem - scale;
        quo[0] = 1'b1;
      end
    end
    return quo[ValueW-1:0];
  endfunction

  // Mostly small or log-spread indices, keeping the digit count and run time low
  function automatic logic [IndexW-1:0] pick_index();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return IndexW'($urandom_range(0, 1023));
    if (sel < 65) return $urandom >> $urandom_range(0, 31);
    if (sel < 90) return $urandom;
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return IndexW'(1) << $urandom_range(0, IndexW - 1);
      default: return ~(IndexW'(1) << $urandom_range(0, IndexW - 1));
    endcase
  endfunction

  task automatic apb_write(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apb_read(input logic [CfgAddrW-1:0] addr, output logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = addr;
    @(negedge clk_i);
    penable = 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    data = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_base_readback();
    logic [CfgDataW-1:0] data;
    apb_read(BaseAddr, data);
    if (data !== CfgDataW'(cfg_base)) begin
      $display("%0t: base readback mismatch: expected %h, got %h", $time,
               CfgDataW'(cfg_base), data);
      error_count++;
    end
  endtask

  // Offer one index beat and record its expected inverse at acceptance
  task automatic send_index(input logic [IndexW-1:0] idx);
    int gap;
    inverse_exp_t exp_item;
    gap = sender_idle ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.index = idx;
    forever begin
      @(posedge clk_i);
      if (in_if.ready) break;
    end
    exp_item.index = idx;
    exp_item.value = radical_inverse(idx, cfg_base);
    expected_inverses.push_back(exp_item);
  endtask

  // Drop valid and wait until every expected beat has come out
  task automatic wait_inverses_drained();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (expected_inverses.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_base(input logic [BaseW-1:0] radix);
    logic [CfgDataW-1:0] data;
    wait_inverses_drained();
    data = $urandom;
    data[BaseW-1:0] = radix;
    apb_write(BaseAddr, data);
    cfg_base = radix;
    check_base_readback();
  endtask

  task automatic test_reset_base();
    check_base_readback();
    send_index('0);
    send_index(32'd1);
    send_index(32'd6);
    send_index('1);
    send_index(32'h8000_0000);
    send_index(32'h5555_5555);
  endtask

  task automatic test_base_extremes();
    set_base(8'd3);
    send_index(32'd1);
    send_index(32'd9);
    send_index('1);
    set_base(8'd255);
    send_index(32'd254);
    send_index(32'd255);
    send_index('1);
  endtask

  // Radix values zero and one act as radix two
  task automatic test_base_below_two();
    set_base(8'd0);
    send_index(32'd1);
    send_index(32'd6);
    send_index('1);
    set_base(8'd1);
    send_index(32'd11);
    send_index(32'hAAAA_AAAA);
  endtask

  // Writes outside the register list must leave base untouched
  task automatic test_unused_register();
    set_base(8'd5);
    apb_write(UnusedAddr, $urandom);
    apb_write(UnusedAddr, 32'hFFFF_FFFF);
    check_base_readback();
    send_index(32'd24);
    send_index(32'd1234);
  endtask

  // Hold the output off so the block fills and stalls its input
  task automatic test_output_stall();
    set_base(8'd2);
    sender_idle = 1'b0;
    sink_hold_cycles = HoldCycles;
    for (int i = 0; i < 8; i++) send_index(IndexW'($urandom_range(0, 63)));
    wait_inverses_drained();
  endtask

  // Pause the sender until all results are back, then resume
  task automatic test_drain_pause();
    sender_idle = 1'b1;
    sink_idle = 1'b1;
    for (int i = 0; i < 5; i++) send_index(pick_index());
    wait_inverses_drained();
    for (int i = 0; i < 5; i++) send_index(pick_index());
  endtask

  task automatic test_random_phases();
    logic [BaseW-1:0] radices[8];
    radices = '{8'd2, 8'd3, 8'd255, 8'd0, 8'd1, 8'd7, 8'd0, 8'd0};
    radices[6] = BaseW'($urandom_range(2, 255));
    radices[7] = BaseW'($urandom_range(0, 255));
    for (int p = 0; p < 8; p++) begin
      set_base(radices[p]);
      case (p % 3)
        0: begin
          sender_idle = 1'b1;
          sink_idle = 1'b1;
        end
        1: begin
          sender_idle = 1'b0;
          sink_idle = 1'b0;
        end
        default: begin
          sender_idle = $urandom_range(0, 1);
          sink_idle = !sender_idle;
        end
      endcase
      for (int i = 0; i < PhaseItems; i++) send_index(pick_index());
    end
  endtask

  // Result sink: random stall before each beat while sink_idle is set, plus a long hold on request
  initial begin : value_sink
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles > 0) begin
        out_if.ready = 1'b0;
        repeat (sink_hold_cycles) @(negedge clk_i);
        sink_hold_cycles = 0;
      end
      stall = sink_idle ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      forever begin
        @(posedge clk_i);
        if (out_if.valid) break;
      end
    end
  end

  // Compare each value beat with the oldest expected inverse
  always @(posedge clk_i) begin
    inverse_exp_t exp_item;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_inverses.size() == 0) begin
        $display("%0t: unexpected value beat: expected none, got %h", $time, out_if.value);
        error_count++;
      end else begin
        exp_item = expected_inverses.pop_front();
        if (out_if.value !== exp_item.value) begin
          $display("%0t: value mismatch for index %h base %0d: expected %h, got %h",
                   $time, exp_item.index, cfg_base, exp_item.value, out_if.value);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.index = '0;
    cfg_base = BaseReset;
    error_count = 0;
    idle_cycles = 0;
    sender_idle = 1'b1;
    sink_idle = 1'b1;
    sink_hold_cycles = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_base();
    test_base_extremes();
    test_base_below_two();
    test_unused_register();
    test_output_stall();
    test_drain_pause();
    test_random_phases();

    wait_inverses_drained();
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
